### rtl/frame_deframer_crc16_check_core_defines.svh
// Assertion macros shared by the deframer RTL.
// FDC_ASSERT checks a property while reset is low.
// FDC_ASSERT_ALWAYS checks a property at every rising clock edge, reset included.
`ifndef FRAME_DEFRAMER_CRC16_CHECK_CORE_DEFINES_SVH
`define FRAME_DEFRAMER_CRC16_CHECK_CORE_DEFINES_SVH

`ifndef SYNTH
`define FDC_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FDC_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FDC_ASSERT(lbl, clock, reset, prop, msg)
`define FDC_ASSERT_ALWAYS(lbl, clock, prop, msg)
`endif

`endif

### rtl/fdc_pkg.sv
package fdc_pkg;

  // Frame layout
  localparam int unsigned HDR_LEN = 13;
  localparam int unsigned CRC_LEN = 2;
  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = 9'd511;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_CRC       = 3'd3;
  localparam logic [2:0] ST_VERSION   = 3'd4;
  localparam logic [2:0] ST_TYPE      = 3'd5;
  localparam logic [2:0] ST_FLAGS     = 3'd6;

  // Configuration register map (index = paddr / 4)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_VERSION   = 3'd0;
  localparam logic [2:0] REG_DATA_TYPE = 3'd1;
  localparam logic [2:0] REG_ACK_TYPE  = 3'd2;
  localparam logic [2:0] REG_FLAG_MASK = 3'd3;
  localparam logic [2:0] REG_MAX_PAY   = 3'd4;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  frame_flags;
    logic [7:0]  frame_type;
    logic [7:0]  hop_limit;
    logic [15:0] network_number;
    logic [15:0] source_number;
    logic [15:0] dest_number;
    logic [15:0] sequence_number;
    logic [7:0]  payload_length;
  } result_t;

  // One byte of CRC update, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/fdc_if.sv
// Byte stream into the deframer
interface fdc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result items out of the deframer
interface fdc_result_if;
  logic        valid;
  logic        ready;
  logic        is_summary;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [7:0]  frame_flags;
  logic [7:0]  frame_type;
  logic [7:0]  hop_limit;
  logic [15:0] network_number;
  logic [15:0] source_number;
  logic [15:0] dest_number;
  logic [15:0] sequence_number;
  logic [7:0]  payload_length;

  modport source (
    output valid, output is_summary, output payload_byte, output status,
    output frame_flags, output frame_type, output hop_limit, output network_number,
    output source_number, output dest_number, output sequence_number,
    output payload_length, input ready
  );
  modport sink (
    input valid, input is_summary, input payload_byte, input status,
    input frame_flags, input frame_type, input hop_limit, input network_number,
    input source_number, input dest_number, input sequence_number,
    input payload_length, output ready
  );
endinterface

### rtl/frame_deframer_crc16_check_core.sv
// Frame deframer with CRC-16/CCITT-FALSE check. Takes up to one frame byte per
// cycle on rx_bytes (last_byte marks the final byte) and checks a 13-byte
// header, the payload length and a little-endian CRC over header and payload.
// Each payload byte comes out at once as a tentative item (is_summary = 0);
// after the last byte one summary item follows with the header fields and a
// status (0 ok, 1 bad length, 2 payload too large, 3 crc, 4 version, 5 type,
// 6 flags). Every byte is handled in the cycle it is accepted, and its items
// enter a FIFO_DEPTH-entry result queue, from which results shows them in
// order. rx_bytes.ready is high whenever the queue has room for two items,
// so a byte is taken every cycle as long as results drains one item per
// cycle; a frame of N bytes never makes more than N items.
// Configuration registers (APB, byte address 4 * index) are to be written
// between frames; the block itself does not enforce this.
`include "frame_deframer_crc16_check_core_defines.svh"

module frame_deframer_crc16_check_core #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  fdc_byte_if.sink                      rx_bytes,
  fdc_result_if.source                  results,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import fdc_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // Configuration registers
  byte_t version_value;
  byte_t data_type_code;
  byte_t ack_type_code;
  byte_t allowed_flag_mask;
  byte_t max_payload;

  // Frame state
  logic [POS_W-1:0] byte_position;
  logic [15:0]      running_crc;
  byte_t            header_store [HDR_LEN];
  logic [15:0]      received_crc_store;

  logic [POS_W-1:0] byte_position_next;
  logic [15:0]      running_crc_next;
  byte_t            header_store_next [HDR_LEN];
  logic [15:0]      received_crc_store_next;

  // Result queue
  result_t          fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;

  logic             in_accept;
  logic             out_accept;
  logic             cfg_write;
  byte_t            din;
  byte_t            plen;
  logic [POS_W-1:0] payload_end;
  logic             in_payload;
  logic [2:0]       status_calc;
  result_t          pay_item;
  result_t          sum_item;
  result_t          first_item;
  logic [1:0]       push_n;
  logic [PTR_W-1:0] wr_ptr_inc;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign pready     = 1'b1;
  assign cfg_write  = psel & penable & pwrite & pready;
  assign in_accept  = rx_bytes.valid & rx_bytes.ready;
  assign out_accept = results.valid & results.ready;
  assign din        = rx_bytes.data_byte;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      version_value     <= 8'd1;
      data_type_code    <= 8'd0;
      ack_type_code     <= 8'd1;
      allowed_flag_mask <= 8'd0;
      max_payload       <= 8'd255;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_VERSION:   version_value     <= pwdata[7:0];
        REG_DATA_TYPE: data_type_code    <= pwdata[7:0];
        REG_ACK_TYPE:  ack_type_code     <= pwdata[7:0];
        REG_FLAG_MASK: allowed_flag_mask <= pwdata[7:0];
        REG_MAX_PAY:   max_payload       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_VERSION:   prdata[7:0] = version_value;
      REG_DATA_TYPE: prdata[7:0] = data_type_code;
      REG_ACK_TYPE:  prdata[7:0] = ack_type_code;
      REG_FLAG_MASK: prdata[7:0] = allowed_flag_mask;
      REG_MAX_PAY:   prdata[7:0] = max_payload;
      default:       prdata      = '0;
    endcase
  end

  // Advance the frame state by one byte
  always_comb begin
    plen = (byte_position == POS_W'(HDR_LEN - 1)) ? din : header_store[HDR_LEN-1];
    payload_end = POS_W'(HDR_LEN) + {1'b0, plen};
    in_payload  = (byte_position >= POS_W'(HDR_LEN)) && (byte_position < payload_end);

    for (int i = 0; i < HDR_LEN; i++) begin
      header_store_next[i] = (byte_position == POS_W'(i)) ? din : header_store[i];
    end

    if ((byte_position < POS_W'(HDR_LEN)) || in_payload) begin
      running_crc_next = crc_byte(running_crc, din);
    end else begin
      running_crc_next = running_crc;
    end

    received_crc_store_next = received_crc_store;
    if (byte_position == payload_end) begin
      received_crc_store_next[7:0] = din;
    end else if (byte_position == payload_end + POS_W'(1)) begin
      received_crc_store_next[15:8] = din;
    end

    byte_position_next = (byte_position != POS_MAX) ? byte_position + POS_W'(1)
                                                    : byte_position;
  end

  // Pick the frame status, highest priority first
  always_comb begin
    if (byte_position_next < POS_W'(HDR_LEN + CRC_LEN)) begin
      status_calc = ST_BAD_LEN;
    end else if (plen > max_payload) begin
      status_calc = ST_TOO_LARGE;
    end else if (byte_position_next != payload_end + POS_W'(CRC_LEN)) begin
      status_calc = ST_BAD_LEN;
    end else if (received_crc_store_next != running_crc_next) begin
      status_calc = ST_CRC;
    end else if (header_store_next[0] != version_value) begin
      status_calc = ST_VERSION;
    end else if ((header_store_next[2] != data_type_code) &&
                 (header_store_next[2] != ack_type_code)) begin
      status_calc = ST_TYPE;
    end else if ((header_store_next[1] & ~allowed_flag_mask) != 8'd0) begin
      status_calc = ST_FLAGS;
    end else begin
      status_calc = ST_OK;
    end
  end

  // Build the payload and summary items
  always_comb begin
    pay_item              = '0;
    pay_item.payload_byte = din;

    sum_item                 = '0;
    sum_item.is_summary      = 1'b1;
    sum_item.status          = status_calc;
    sum_item.frame_flags     = header_store_next[1];
    sum_item.frame_type      = header_store_next[2];
    sum_item.hop_limit       = header_store_next[3];
    sum_item.network_number  = {header_store_next[5], header_store_next[4]};
    sum_item.source_number   = {header_store_next[7], header_store_next[6]};
    sum_item.dest_number     = {header_store_next[9], header_store_next[8]};
    sum_item.sequence_number = {header_store_next[11], header_store_next[10]};
    sum_item.payload_length  = header_store_next[12];

    first_item = in_payload ? pay_item : sum_item;
    push_n     = in_accept ? ({1'b0, in_payload} + {1'b0, rx_bytes.last_byte}) : 2'd0;
  end

  // Update, hold or clear the frame state
  always_ff @(posedge clk) begin
    if (rst || (in_accept && rx_bytes.last_byte)) begin
      byte_position      <= '0;
      running_crc        <= CRC_INIT;
      received_crc_store <= '0;
      for (int i = 0; i < HDR_LEN; i++) begin
        header_store[i] <= '0;
      end
    end else if (in_accept) begin
      byte_position      <= byte_position_next;
      running_crc        <= running_crc_next;
      received_crc_store <= received_crc_store_next;
      for (int i = 0; i < HDR_LEN; i++) begin
        header_store[i] <= header_store_next[i];
      end
    end
  end

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_inc  = ptr_inc(wr_ptr);
    wr_ptr_next = wr_ptr;
    case (push_n)
      2'd1:    wr_ptr_next = wr_ptr_inc;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = out_accept ? ptr_inc(rd_ptr) : rd_ptr;
    count_next  = count + CNT_W'(push_n) - CNT_W'(out_accept);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Write up to two items into the queue
  always_ff @(posedge clk) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if ((push_n != 2'd0) && (wr_ptr == PTR_W'(i))) begin
        fifo[i] <= first_item;
      end else if ((push_n == 2'd2) && (wr_ptr_inc == PTR_W'(i))) begin
        fifo[i] <= sum_item;
      end
    end
  end

  // Drive the channels
  assign rx_bytes.ready          = (count <= ROOM_LIMIT);
  assign results.valid           = (count != '0);
  assign results.is_summary      = fifo[rd_ptr].is_summary;
  assign results.payload_byte    = fifo[rd_ptr].payload_byte;
  assign results.status          = fifo[rd_ptr].status;
  assign results.frame_flags     = fifo[rd_ptr].frame_flags;
  assign results.frame_type      = fifo[rd_ptr].frame_type;
  assign results.hop_limit       = fifo[rd_ptr].hop_limit;
  assign results.network_number  = fifo[rd_ptr].network_number;
  assign results.source_number   = fifo[rd_ptr].source_number;
  assign results.dest_number     = fifo[rd_ptr].dest_number;
  assign results.sequence_number = fifo[rd_ptr].sequence_number;
  assign results.payload_length  = fifo[rd_ptr].payload_length;

  `FDC_ASSERT_ALWAYS(a_count_bound, clk, (rst || (count <= CNT_W'(FIFO_DEPTH))),
    "result queue overfilled")
  `FDC_ASSERT(a_summary_queued, clk, rst, (in_accept && rx_bytes.last_byte) |=> (count != '0),
    "summary item missing after last byte")
  `FDC_ASSERT(a_frame_cleared, clk, rst,
    (in_accept && rx_bytes.last_byte) |=> (byte_position == '0 && running_crc == CRC_INIT),
    "frame state not cleared after last byte")
  `FDC_ASSERT(a_pos_saturates, clk, rst,
    (in_accept && !rx_bytes.last_byte && byte_position == POS_MAX) |=>
      (byte_position == POS_MAX),
    "byte position wrapped")

endmodule

### dv/frame_deframer_crc16_check_core_test.sv
`timescale 1ns / 1ps

module frame_deframer_crc16_check_core_test;
  import fdc_pkg::*;

  // Register index that maps to no register; writes there must be dropped
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int unsigned IDLE_PCT = 22;
  localparam int unsigned PHASE_ITEMS = 270;

  typedef enum int {
    FR_GOOD, FR_SHORT, FR_TRUNC, FR_LONG, FR_BAD_CRC, FR_BAD_LEN, FR_TOO_LARGE,
    FR_BAD_VER, FR_BAD_TYPE, FR_BAD_FLAGS, FR_OVERLONG, FR_NOISE
  } frame_kind_t;

  typedef struct {
    byte_t data;
    logic  is_last;
    bit    drain;
  } rx_item_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  fdc_byte_if rx_bytes ();
  fdc_result_if results ();

  frame_deframer_crc16_check_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .rx_bytes (rx_bytes),
    .results  (results),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Configuration as the block should hold it
  byte_t want_version;
  byte_t want_data_type;
  byte_t want_ack_type;
  byte_t want_flag_mask;
  byte_t want_max_pay;

  // Frame state of the predictor
  int unsigned frame_pos;
  logic [15:0] frame_crc;
  byte_t       hdr_bytes [HDR_LEN];
  logic [15:0] sent_crc;

  rx_item_t byte_queue [$];
  result_t  expected_items [$];
  int unsigned error_count;
  bit byte_taken;
  bit steady;

  // CRC-16/CCITT-FALSE, one input bit at a time
  function automatic logic [15:0] crc_update(logic [15:0] c, byte_t b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    frame_pos = 0;
    frame_crc = CRC_INIT;
    sent_crc = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
  endfunction

  // Advance the frame state by one accepted byte and queue its results
  function automatic void predict_byte(byte_t b, logic is_last);
    int unsigned pos;
    int unsigned plen;
    int unsigned count;
    logic [2:0] st;
    result_t r;
    pos = frame_pos;
    plen = hdr_bytes[HDR_LEN-1];
    if (pos < HDR_LEN) begin
      hdr_bytes[pos] = b;
      frame_crc = crc_update(frame_crc, b);
      if (pos == HDR_LEN - 1) plen = b;
    end else if (pos < HDR_LEN + plen) begin
      frame_crc = crc_update(frame_crc, b);
      r = '0;
      r.payload_byte = b;
      expected_items.push_back(r);
    end else if (pos == HDR_LEN + plen) begin
      sent_crc[7:0] = b;
    end else if (pos == HDR_LEN + plen + 1) begin
      sent_crc[15:8] = b;
    end
    if (pos < POS_MAX) frame_pos = pos + 1;

    if (is_last) begin
      count = frame_pos;
      if (count < HDR_LEN + CRC_LEN) st = ST_BAD_LEN;
      else if (plen > want_max_pay) st = ST_TOO_LARGE;
      else if (count != HDR_LEN + plen + CRC_LEN) st = ST_BAD_LEN;
      else if (sent_crc != frame_crc) st = ST_CRC;
      else if (hdr_bytes[0] != want_version) st = ST_VERSION;
      else if (hdr_bytes[2] != want_data_type && hdr_bytes[2] != want_ack_type) st = ST_TYPE;
      else if ((hdr_bytes[1] & ~want_flag_mask) != 8'h00) st = ST_FLAGS;
      else st = ST_OK;
      r = '0;
      r.is_summary = 1'b1;
      r.status = st;
      r.frame_flags = hdr_bytes[1];
      r.frame_type = hdr_bytes[2];
      r.hop_limit = hdr_bytes[3];
      r.network_number = {hdr_bytes[5], hdr_bytes[4]};
      r.source_number = {hdr_bytes[7], hdr_bytes[6]};
      r.dest_number = {hdr_bytes[9], hdr_bytes[8]};
      r.sequence_number = {hdr_bytes[11], hdr_bytes[10]};
      r.payload_length = hdr_bytes[12];
      expected_items.push_back(r);
      clear_frame();
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Compare one result item with the oldest expectation
  task automatic check_result();
    result_t got;
    result_t want;
    got.is_summary = results.is_summary;
    got.payload_byte = results.payload_byte;
    got.status = results.status;
    got.frame_flags = results.frame_flags;
    got.frame_type = results.frame_type;
    got.hop_limit = results.hop_limit;
    got.network_number = results.network_number;
    got.source_number = results.source_number;
    got.dest_number = results.dest_number;
    got.sequence_number = results.sequence_number;
    got.payload_length = results.payload_length;
    if (expected_items.size() == 0) begin
      report_mismatch("result item with nothing expected", got.is_summary, 0);
      return;
    end
    want = expected_items.pop_front();
    if (got.is_summary !== want.is_summary)
      report_mismatch("is_summary", got.is_summary, want.is_summary);
    if (got.payload_byte !== want.payload_byte)
      report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.frame_flags !== want.frame_flags)
      report_mismatch("frame_flags", got.frame_flags, want.frame_flags);
    if (got.frame_type !== want.frame_type)
      report_mismatch("frame_type", got.frame_type, want.frame_type);
    if (got.hop_limit !== want.hop_limit)
      report_mismatch("hop_limit", got.hop_limit, want.hop_limit);
    if (got.network_number !== want.network_number)
      report_mismatch("network_number", got.network_number, want.network_number);
    if (got.source_number !== want.source_number)
      report_mismatch("source_number", got.source_number, want.source_number);
    if (got.dest_number !== want.dest_number)
      report_mismatch("dest_number", got.dest_number, want.dest_number);
    if (got.sequence_number !== want.sequence_number)
      report_mismatch("sequence_number", got.sequence_number, want.sequence_number);
    if (got.payload_length !== want.payload_length)
      report_mismatch("payload_length", got.payload_length, want.payload_length);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input logic [2:0] idx, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write a register; if it is a known one, mirror it and read it back
  task automatic cfg_write(logic [2:0] idx, byte_t value);
    logic [31:0] rd;
    bit known;
    apb_access(idx, 1'b1, {24'($urandom_range(0, 16777215)), value}, rd);
    known = 1'b1;
    case (idx)
      REG_VERSION: want_version = value;
      REG_DATA_TYPE: want_data_type = value;
      REG_ACK_TYPE: want_ack_type = value;
      REG_FLAG_MASK: want_flag_mask = value;
      REG_MAX_PAY: want_max_pay = value;
      default: known = 1'b0;
    endcase
    if (known) begin
      apb_access(idx, 1'b0, '0, rd);
      if (rd[7:0] !== value) report_mismatch("register read back", rd[7:0], value);
    end
  endtask

  task automatic set_config(byte_t ver, byte_t dtype, byte_t atype, byte_t mask, byte_t maxp);
    cfg_write(REG_VERSION, ver);
    cfg_write(REG_DATA_TYPE, dtype);
    cfg_write(REG_ACK_TYPE, atype);
    cfg_write(REG_FLAG_MASK, mask);
    cfg_write(REG_MAX_PAY, maxp);
  endtask

  // Wait until the block has drained and every expected item has come
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (byte_queue.size() != 0 || rx_bytes.valid || expected_items.size() != 0);
    repeat (5) @(posedge clk);
  endtask

  task automatic push_bytes(byte_t f[$], bit drain);
    rx_item_t it;
    foreach (f[i]) begin
      it.data = f[i];
      it.is_last = (i == f.size() - 1);
      it.drain = drain && (i == 0);
      byte_queue.push_back(it);
    end
  endtask

  // Build one frame of the given kind with random content
  task automatic queue_frame(frame_kind_t kind, bit drain, output int unsigned added);
    byte_t f[$];
    byte_t fl;
    byte_t ty;
    logic [15:0] c;
    int unsigned plen;
    int unsigned cut;
    int unsigned bitpos;
    int unsigned lim;

    // header
    f.push_back(kind == FR_BAD_VER ? want_version ^ (8'h01 << $urandom_range(0, 7))
                                   : want_version);
    fl = byte_t'($urandom);
    if (kind != FR_BAD_FLAGS) begin
      fl &= want_flag_mask;
    end else if (want_flag_mask != 8'hFF) begin
      do bitpos = $urandom_range(0, 7); while (want_flag_mask[bitpos]);
      fl |= 8'h01 << bitpos;
    end
    f.push_back(fl);
    if (kind == FR_BAD_TYPE) begin
      do ty = byte_t'($urandom); while (ty == want_data_type || ty == want_ack_type);
    end else begin
      ty = $urandom_range(0, 1) ? want_data_type : want_ack_type;
    end
    f.push_back(ty);
    repeat (9) f.push_back(byte_t'($urandom));

    // payload length
    lim = (want_max_pay < 8) ? want_max_pay : 8;
    if (kind == FR_TOO_LARGE && want_max_pay < 255) begin
      cut = 254 - want_max_pay;
      plen = want_max_pay + 1 + $urandom_range(0, cut < 4 ? cut : 4);
    end else if ($urandom_range(0, 9) == 0) begin
      plen = $urandom_range(0, want_max_pay);
    end else begin
      plen = $urandom_range(0, lim);
    end
    f.push_back(kind == FR_BAD_LEN ? byte_t'(plen ^ (1 << $urandom_range(0, 2))) : byte_t'(plen));

    // payload and trailing CRC
    repeat (plen) f.push_back(byte_t'($urandom));
    c = CRC_INIT;
    foreach (f[i]) c = crc_update(c, f[i]);
    if (kind == FR_BAD_CRC) c ^= 16'h0001 << $urandom_range(0, 15);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);

    case (kind)
      FR_SHORT: begin
        cut = $urandom_range(1, HDR_LEN + CRC_LEN - 1);
        while (f.size() > cut) void'(f.pop_back());
      end
      FR_TRUNC: begin
        cut = f.size() - HDR_LEN - CRC_LEN;
        cut = $urandom_range(1, cut > 1 ? cut : 1);
        repeat (cut) void'(f.pop_back());
      end
      FR_LONG: repeat ($urandom_range(1, 4)) f.push_back(byte_t'($urandom));
      FR_OVERLONG: begin
        cut = POS_MAX + 1 + $urandom_range(0, 20);
        while (f.size() < cut) f.push_back(byte_t'($urandom));
      end
      FR_NOISE: begin
        f.delete();
        repeat ($urandom_range(1, 40)) f.push_back(byte_t'($urandom));
      end
      default: ;
    endcase
    push_bytes(f, drain);
    added = f.size();
  endtask

  function automatic frame_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return FR_GOOD;
    if (r < 52) return FR_SHORT;
    if (r < 58) return FR_TRUNC;
    if (r < 64) return FR_LONG;
    if (r < 71) return FR_BAD_CRC;
    if (r < 77) return FR_BAD_LEN;
    if (r < 83) return FR_TOO_LARGE;
    if (r < 88) return FR_BAD_VER;
    if (r < 93) return FR_BAD_TYPE;
    if (r < 97) return FR_BAD_FLAGS;
    if (r < 98) return FR_OVERLONG;
    return FR_NOISE;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Byte driver: hold an item until taken, then advance or idle
  always @(negedge clk) begin : feed_bytes
    rx_item_t nxt;
    if (rst) begin
      rx_bytes.valid <= 1'b0;
    end else if (!rx_bytes.valid || byte_taken) begin
      byte_taken = 1'b0;
      if (byte_queue.size() != 0 &&
          !(byte_queue[0].drain && expected_items.size() != 0) &&
          (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = byte_queue.pop_front();
        rx_bytes.valid <= 1'b1;
        rx_bytes.data_byte <= nxt.data;
        rx_bytes.last_byte <= nxt.is_last;
      end else begin
        rx_bytes.valid <= 1'b0;
        rx_bytes.data_byte <= byte_t'($urandom);
        rx_bytes.last_byte <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random unless steady is set
  always @(negedge clk) begin
    results.ready <= !rst && (steady || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: check results first, then predict from the accepted byte
  always @(posedge clk) begin
    if (!rst) begin
      if (results.valid && results.ready) check_result();
      if (rx_bytes.valid && rx_bytes.ready) begin
        predict_byte(rx_bytes.data_byte, rx_bytes.last_byte);
        byte_taken = 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    byte_t f[$];
    logic [15:0] c;
    int unsigned phase_items;
    int unsigned added;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_bytes.valid = 1'b0;
    rx_bytes.data_byte = '0;
    rx_bytes.last_byte = 1'b0;
    results.ready = 1'b0;
    steady = 1'b0;
    byte_taken = 1'b0;
    error_count = 0;
    want_version = 8'd1;
    want_data_type = 8'd0;
    want_ack_type = 8'd1;
    want_flag_mask = 8'd0;
    want_max_pay = 8'd255;
    clear_frame();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Minimal good frame: all-ones hop limit and number fields, empty payload
    f = '{8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
          8'hFF, 8'hFF, 8'h00};
    c = CRC_INIT;
    foreach (f[i]) c = crc_update(c, f[i]);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    push_bytes(f, 1'b0);
    // Single-byte frame, then a short frame cut inside the header
    f = '{8'hFF};
    push_bytes(f, 1'b1);
    f = '{8'h01, 8'hA5, 8'h01, 8'h80, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56};
    push_bytes(f, 1'b0);
    wait_idle();

    // Random phases, each under its own configuration
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
          cfg_write(REG_SPARE, byte_t'($urandom));
        end
        1: set_config(8'd255, 8'd255, 8'd254, 8'd255, 8'd255);
        2: set_config(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                      byte_t'($urandom), byte_t'($urandom_range(8, 40)));
        default: set_config(8'd1, 8'd0, 8'd1, 8'd0, 8'd255);
      endcase
      steady = (ph == 1);
      phase_items = 0;
      if (ph == 3) begin
        queue_frame(FR_OVERLONG, 1'b0, added);
        phase_items += added;
      end
      while (phase_items < PHASE_ITEMS) begin
        queue_frame(pick_kind(), $urandom_range(0, 19) == 0, added);
        phase_items += added;
      end
      wait_idle();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
